/* design/mtg_pkg.sv */
// shared constants, types and word functions of the mersenne twister generator
package mtg_pkg;

	localparam int STATE_DEPTH = 624;
	localparam int SHIFT_DIST  = 397;
	localparam int WORD_W      = 32;
	localparam int IDX_W       = $clog2(STATE_DEPTH + 1);

	localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] HIGH_BIT   = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOW_BITS   = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] TEMPER_B   = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C   = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] SEED_MUL   = 32'd1812433253;
	localparam logic [WORD_W-1:0] SEED_RESET = 32'd5489;

	// control from the top level to the seeding unit
	typedef struct packed {
		logic start;
		logic step;
	} seed_ctrl_t;

	// one step of the twist recurrence
	function automatic logic [WORD_W-1:0] twist_word(
		input logic [WORD_W-1:0] w_cur,
		input logic [WORD_W-1:0] w_nxt,
		input logic [WORD_W-1:0] w_far
	);
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] w;
		y = (w_cur & HIGH_BIT) | (w_nxt & LOW_BITS);
		w = w_far ^ (y >> 1);
		if (y[0]) begin
			w = w ^ TWIST_XOR;
		end
		return w;
	endfunction

	// output tempering
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w_in);
		logic [WORD_W-1:0] y;
		y = w_in;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

/* design/mtg_cell.sv */
// one state word of the circular shift chain
module mtg_cell (
	input  logic                       clk,
	input  logic                       shift_en,
	input  logic [mtg_pkg::WORD_W-1:0] din,
	output logic [mtg_pkg::WORD_W-1:0] dout
);

	logic [mtg_pkg::WORD_W-1:0] word_q;

	// take the neighbour's word on every shift
	always_ff @(posedge clk) begin
		if (shift_en) begin
			word_q <= din;
		end
	end

	assign dout = word_q;

endmodule

/* design/mtg_seeder.sv */
// seeding recurrence: one new pool word per step from the multiplier chain
module mtg_seeder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mtg_pkg::WORD_W-1:0] seed_value,
	input  mtg_pkg::seed_ctrl_t        ctrl,
	output logic [mtg_pkg::WORD_W-1:0] seed_word,
	output logic                       last
);

	logic [mtg_pkg::WORD_W-1:0] x_q;
	logic [mtg_pkg::IDX_W-1:0]  idx_q;
	logic [mtg_pkg::WORD_W-1:0] mix;
	logic [mtg_pkg::WORD_W-1:0] prod;
	logic [mtg_pkg::WORD_W-1:0] x_next;

	// x[i] = mul * (x[i-1] ^ (x[i-1] >> 30)) + i, modulo 2^32
	assign mix    = x_q ^ (x_q >> 30);
	assign prod   = mix * mtg_pkg::SEED_MUL;
	assign x_next = prod + mtg_pkg::WORD_W'(idx_q);

	// index of the word held in x_q plus one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (ctrl.start) begin
			idx_q <= mtg_pkg::IDX_W'(1);
		end else if (ctrl.step) begin
			idx_q <= idx_q + mtg_pkg::IDX_W'(1);
		end
	end

	// current pool word of the recurrence
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			x_q <= seed_value;
		end else if (ctrl.step) begin
			x_q <= x_next;
		end
	end

	assign seed_word = x_q;
	assign last      = (idx_q == mtg_pkg::IDX_W'(mtg_pkg::STATE_DEPTH));

endmodule

/* design/mersenne_twister_generator_unit.sv */
// top level: 624-cell shift chain, seeding unit, on-the-fly twist and tempering
// a plain draw shows its word on m_tdata in the cycle after the input beat
// a seeding draw (reseed set, or first draw after reset) seeds, then draws
// throughput: one word per cycle once seeded, while m_tready is high
// seeding shifts the chain one word per cycle, filling it through its tail
// reset: seed register to 5489, pool marked unseeded, output empty; chain undefined
module mersenne_twister_generator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// bit 0 reseed, bits 7:1 zero
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// bits 31:0 random_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	// seed_value write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_DRAW
	} state_t;

	state_t                     state_q;
	logic                       seeded_q;
	logic                       m_tvalid_q;
	logic [mtg_pkg::WORD_W-1:0] m_tdata_q;
	logic [mtg_pkg::WORD_W-1:0] seed_q;

	logic                       out_free;
	logic                       in_beat;
	logic                       need_seed;
	logic                       draw_fire;
	logic                       shift_en;
	logic                       seed_last;
	logic [mtg_pkg::WORD_W-1:0] seed_word;
	logic [mtg_pkg::WORD_W-1:0] new_word;
	logic [mtg_pkg::WORD_W-1:0] tail_word;
	mtg_pkg::seed_ctrl_t        seed_ctrl;
	logic [mtg_pkg::WORD_W-1:0] cell_word [mtg_pkg::STATE_DEPTH];

	// seed register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= mtg_pkg::SEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	// handshake and sequencing
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_beat   = s_tvalid && s_tready;
	assign need_seed = s_tdata[0] || !seeded_q;
	assign draw_fire = (in_beat && !need_seed) || ((state_q == ST_DRAW) && out_free);

	assign seed_ctrl.start = in_beat && need_seed;
	assign seed_ctrl.step  = (state_q == ST_SEED);

	// twist the head word on the fly, feed the tail
	assign new_word  = mtg_pkg::twist_word(cell_word[0], cell_word[1],
		cell_word[mtg_pkg::SHIFT_DIST]);
	assign tail_word = seed_ctrl.step ? seed_word : new_word;
	assign shift_en  = seed_ctrl.step || draw_fire;

	mtg_seeder u_seeder (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_value (seed_q),
		.ctrl       (seed_ctrl),
		.seed_word  (seed_word),
		.last       (seed_last)
	);

	// circular chain of state words, cell 0 is the next word to twist
	for (genvar gi = 0; gi < mtg_pkg::STATE_DEPTH; gi++) begin : g_cell
		if (gi == mtg_pkg::STATE_DEPTH - 1) begin : g_tail
			mtg_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.din      (tail_word),
				.dout     (cell_word[gi])
			);
		end else begin : g_body
			mtg_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.din      (cell_word[gi+1]),
				.dout     (cell_word[gi])
			);
		end
	end

	// state machine and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			seeded_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (draw_fire) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= mtg_pkg::temper(new_word);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (seed_ctrl.start) begin
						state_q  <= ST_SEED;
						seeded_q <= 1'b0;
					end
				end
				ST_SEED: begin
					if (seed_last) begin
						state_q  <= ST_DRAW;
						seeded_q <= 1'b1;
					end
				end
				ST_DRAW: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* design/mtg_checker.sv */
// port-level checks of the generator, bound to the top level
module mtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_ready
);

	// a waiting result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
	else $error("result beat dropped or changed while stalled");

	// no new beat taken while the output is stuck
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
	else $error("input beat taken while output register is full");

	// a reseed beat starts a seeding pass that blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata[0] |=> !s_tready && !m_tvalid)
	else $error("input not blocked during seeding");

	// the seed register never stalls a write
	assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
	else $error("configuration write stalled");

endmodule

bind mersenne_twister_generator_unit mtg_checker u_mtg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);
